// File: rtl/imse_pkg.sv
// Shared types and constants for the image mean squared error block.
// No dependencies; used by every module under rtl/.
`default_nettype none

package imse_pkg;

    // Accepted format codes ("DIB\0" read little-endian for the DIB code)
    localparam logic [31:0] FMT_RAW = 32'h0000_0000;
    localparam logic [31:0] FMT_DIB = 32'h0042_4944;

    localparam logic [6:0] DEPTH_SUPPORTED = 7'd32;
    localparam int unsigned MAX_DIM = 4096;

    localparam int FMT_W   = 32;
    localparam int DEPTH_W = 7;
    localparam int DIM_W   = 13;
    localparam int CH_W    = 8;
    localparam int SQ_W    = 2 * CH_W;         // one squared difference
    localparam int PIX_W   = SQ_W + 2;         // three squared differences
    localparam int SUM_W   = 42;
    localparam int CNT_W   = 25;
    localparam int LEN_W   = 2 * DIM_W;
    localparam int DVS_W   = CNT_W + 2;        // pixel count times three
    localparam int FRAC_W  = 16;
    localparam int Q_W     = 32;
    localparam int DCNT_W  = $clog2(Q_W);

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register map: register i at byte address 4*i
    typedef enum logic [2:0] {
        REG_ORIG_FORMAT = 3'd0,
        REG_CMP_FORMAT  = 3'd1,
        REG_ORIG_DEPTH  = 3'd2,
        REG_CMP_DEPTH   = 3'd3,
        REG_ORIG_WIDTH  = 3'd4,
        REG_ORIG_HEIGHT = 3'd5,
        REG_CMP_WIDTH   = 3'd6,
        REG_CMP_HEIGHT  = 3'd7
    } t_reg_idx;

    localparam logic [FMT_W-1:0]   RST_FORMAT = '0;
    localparam logic [DEPTH_W-1:0] RST_DEPTH  = 7'd32;
    localparam logic [DIM_W-1:0]   RST_DIM    = 13'd1;

    typedef struct packed {
        logic [FMT_W-1:0]   orig_format;
        logic [FMT_W-1:0]   cmp_format;
        logic [DEPTH_W-1:0] orig_depth;
        logic [DEPTH_W-1:0] cmp_depth;
        logic [DIM_W-1:0]   orig_width;
        logic [DIM_W-1:0]   orig_height;
        logic [DIM_W-1:0]   cmp_width;
        logic [DIM_W-1:0]   cmp_height;
    } t_cfg;

    typedef enum logic {
        ST_ACCUM = 1'b0,
        ST_DIV   = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic pix_acc;     // add the accepted pixel pair
        logic div_load;    // frame done and valid: start the divide
        logic err_load;    // frame done and invalid: post an error result
        logic div_step;    // one quotient bit
        logic res_load;    // capture the quotient as result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_pixel;  // next pixel closes the frame
        logic frame_ok;    // formats, depths and sizes agree and are supported
        logic div_done;    // this step produces the last quotient bit
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/imse_cfg.sv
// Configuration register file with APB-style write and read access.
// Depends on imse_pkg.
`default_nettype none

module imse_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [imse_pkg::ADDR_W-1:0] paddr,
    input  wire logic [imse_pkg::DATA_W-1:0] pwdata,
    output logic      [imse_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output imse_pkg::t_cfg                   o_cfg
);

    imse_pkg::t_cfg     r_cfg;
    imse_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = imse_pkg::t_reg_idx'(paddr[imse_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orig_format <= imse_pkg::RST_FORMAT;
            r_cfg.cmp_format  <= imse_pkg::RST_FORMAT;
            r_cfg.orig_depth  <= imse_pkg::RST_DEPTH;
            r_cfg.cmp_depth   <= imse_pkg::RST_DEPTH;
            r_cfg.orig_width  <= imse_pkg::RST_DIM;
            r_cfg.orig_height <= imse_pkg::RST_DIM;
            r_cfg.cmp_width   <= imse_pkg::RST_DIM;
            r_cfg.cmp_height  <= imse_pkg::RST_DIM;
        end else if (w_wr) begin
            unique case (w_idx)
                imse_pkg::REG_ORIG_FORMAT: r_cfg.orig_format <= pwdata;
                imse_pkg::REG_CMP_FORMAT:  r_cfg.cmp_format  <= pwdata;
                imse_pkg::REG_ORIG_DEPTH:
                    r_cfg.orig_depth  <= pwdata[imse_pkg::DEPTH_W-1:0];
                imse_pkg::REG_CMP_DEPTH:
                    r_cfg.cmp_depth   <= pwdata[imse_pkg::DEPTH_W-1:0];
                imse_pkg::REG_ORIG_WIDTH:
                    r_cfg.orig_width  <= pwdata[imse_pkg::DIM_W-1:0];
                imse_pkg::REG_ORIG_HEIGHT:
                    r_cfg.orig_height <= pwdata[imse_pkg::DIM_W-1:0];
                imse_pkg::REG_CMP_WIDTH:
                    r_cfg.cmp_width   <= pwdata[imse_pkg::DIM_W-1:0];
                imse_pkg::REG_CMP_HEIGHT:
                    r_cfg.cmp_height  <= pwdata[imse_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            imse_pkg::REG_ORIG_FORMAT: prdata = r_cfg.orig_format;
            imse_pkg::REG_CMP_FORMAT:  prdata = r_cfg.cmp_format;
            imse_pkg::REG_ORIG_DEPTH:
                prdata = imse_pkg::DATA_W'(r_cfg.orig_depth);
            imse_pkg::REG_CMP_DEPTH:
                prdata = imse_pkg::DATA_W'(r_cfg.cmp_depth);
            imse_pkg::REG_ORIG_WIDTH:
                prdata = imse_pkg::DATA_W'(r_cfg.orig_width);
            imse_pkg::REG_ORIG_HEIGHT:
                prdata = imse_pkg::DATA_W'(r_cfg.orig_height);
            imse_pkg::REG_CMP_WIDTH:
                prdata = imse_pkg::DATA_W'(r_cfg.cmp_width);
            imse_pkg::REG_CMP_HEIGHT:
                prdata = imse_pkg::DATA_W'(r_cfg.cmp_height);
            default: prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/imse_dp.sv
// Datapath: squared-difference accumulator, pixel counter, frame checks,
// bit-serial restoring divider and result register. Depends on imse_pkg.
`default_nettype none

module imse_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire imse_pkg::t_cfg             i_cfg,
    input  wire imse_pkg::t_cmd             i_cmd,
    output imse_pkg::t_sts                  o_sts,
    input  wire logic [imse_pkg::CH_W-1:0]  i_orig_c0,
    input  wire logic [imse_pkg::CH_W-1:0]  i_orig_c1,
    input  wire logic [imse_pkg::CH_W-1:0]  i_orig_c2,
    input  wire logic [imse_pkg::CH_W-1:0]  i_cmp_c0,
    input  wire logic [imse_pkg::CH_W-1:0]  i_cmp_c1,
    input  wire logic [imse_pkg::CH_W-1:0]  i_cmp_c2,
    output logic                            o_status,
    output logic      [imse_pkg::Q_W-1:0]   o_mse_q16
);

    function automatic logic [imse_pkg::SQ_W-1:0] sq_diff(
        input logic [imse_pkg::CH_W-1:0] a,
        input logic [imse_pkg::CH_W-1:0] b
    );
        logic [imse_pkg::CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return imse_pkg::SQ_W'(d) * imse_pkg::SQ_W'(d);
    endfunction

    function automatic logic dim_ok(input logic [imse_pkg::DIM_W-1:0] d);
        return (d != '0) && (32'(d) <= imse_pkg::MAX_DIM);
    endfunction

    logic [imse_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [imse_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [imse_pkg::PIX_W-1:0]  w_pix;
    logic [imse_pkg::LEN_W-1:0]  w_len;
    logic                        w_dims_ok;

    logic [imse_pkg::DVS_W-1:0]  r_rem, n_rem;
    logic [imse_pkg::DVS_W-1:0]  r_dvs;
    logic [imse_pkg::Q_W-1:0]    r_dvd, r_quo, n_quo;
    logic [imse_pkg::DCNT_W-1:0] r_dcnt;
    logic [imse_pkg::DVS_W:0]    w_trial;
    logic                        w_qbit;

    logic                        r_status;
    logic [imse_pkg::Q_W-1:0]    r_mse_q16;

    // Per-pixel error and running totals
    assign w_pix = imse_pkg::PIX_W'(sq_diff(i_orig_c0, i_cmp_c0))
                 + imse_pkg::PIX_W'(sq_diff(i_orig_c1, i_cmp_c1))
                 + imse_pkg::PIX_W'(sq_diff(i_orig_c2, i_cmp_c2));
    assign n_sum = r_sum + imse_pkg::SUM_W'(w_pix);
    assign n_cnt = r_cnt + 1'b1;

    // Frame length; an out-of-range size closes the frame after one pixel
    assign w_dims_ok = dim_ok(i_cfg.orig_width) && dim_ok(i_cfg.orig_height);
    assign w_len = w_dims_ok ? (imse_pkg::LEN_W'(i_cfg.orig_width)
                               * imse_pkg::LEN_W'(i_cfg.orig_height))
                             : imse_pkg::LEN_W'(1);

    assign o_sts.last_pixel = (imse_pkg::LEN_W'(n_cnt) >= w_len);
    assign o_sts.frame_ok   = (i_cfg.orig_format == i_cfg.cmp_format)
                           && (i_cfg.orig_depth == i_cfg.cmp_depth)
                           && (i_cfg.orig_width == i_cfg.cmp_width)
                           && (i_cfg.orig_height == i_cfg.cmp_height)
                           && ((i_cfg.orig_format == imse_pkg::FMT_RAW)
                               || (i_cfg.orig_format == imse_pkg::FMT_DIB))
                           && (i_cfg.orig_depth == imse_pkg::DEPTH_SUPPORTED)
                           && w_dims_ok;
    assign o_sts.div_done   = (r_dcnt == imse_pkg::DCNT_W'(imse_pkg::Q_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.pix_acc) begin
            if (o_sts.last_pixel) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

    // One quotient bit per cycle; remainder stays below the divisor
    assign w_trial = {r_rem, r_dvd[imse_pkg::Q_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_qbit ? imse_pkg::DVS_W'(w_trial - {1'b0, r_dvs})
                            : w_trial[imse_pkg::DVS_W-1:0];
    assign n_quo   = {r_quo[imse_pkg::Q_W-2:0], w_qbit};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= imse_pkg::DVS_W'(n_sum[imse_pkg::SUM_W-1:imse_pkg::FRAC_W]);
            r_dvd <= {n_sum[imse_pkg::FRAC_W-1:0], imse_pkg::FRAC_W'(0)};
            r_dvs <= (imse_pkg::DVS_W'(n_cnt) << 1) + imse_pkg::DVS_W'(n_cnt);
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[imse_pkg::Q_W-2:0], 1'b0};
            r_quo <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_load) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.err_load) begin
            r_status  <= 1'b1;
            r_mse_q16 <= '0;
        end else if (i_cmd.res_load) begin
            r_status  <= 1'b0;
            r_mse_q16 <= n_quo;
        end
    end

    assign o_status  = r_status;
    assign o_mse_q16 = r_mse_q16;

endmodule

`default_nettype wire

// File: rtl/imse_ctrl.sv
// Controller: handshakes, accumulate/divide sequencing, result valid flag.
// Depends on imse_pkg.
`default_nettype none

module imse_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  wire logic     i_ready,
    input  wire imse_pkg::t_sts i_sts,
    output imse_pkg::t_cmd o_cmd
);

    imse_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_in_fire;

    assign o_valid   = r_out_valid;
    // Hold off the closing pixel while the previous result is still unread
    assign o_ready   = (r_state == imse_pkg::ST_ACCUM)
                    && !(r_out_valid && i_sts.last_pixel);
    assign w_in_fire = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            imse_pkg::ST_ACCUM:
                if (w_in_fire && i_sts.last_pixel && i_sts.frame_ok) begin
                    n_state = imse_pkg::ST_DIV;
                end
            imse_pkg::ST_DIV:
                if (i_sts.div_done) begin
                    n_state = imse_pkg::ST_ACCUM;
                end
            default: n_state = imse_pkg::ST_ACCUM;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.pix_acc  = w_in_fire;
        o_cmd.div_load = w_in_fire && i_sts.last_pixel && i_sts.frame_ok;
        o_cmd.err_load = w_in_fire && i_sts.last_pixel && !i_sts.frame_ok;
        o_cmd.div_step = (r_state == imse_pkg::ST_DIV);
        o_cmd.res_load = (r_state == imse_pkg::ST_DIV) && i_sts.div_done;
        n_out_valid    = (r_out_valid && !i_ready) || o_cmd.err_load
                      || o_cmd.res_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imse_pkg::ST_ACCUM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: rtl/image_mean_squared_error.sv
// Top level of the image mean squared error block.
// Depends on imse_pkg, imse_cfg, imse_ctrl and imse_dp.
//
// Streams pixel pairs (three 8-bit channels of an original and a compared
// pixel) and returns one result per frame of orig_width * orig_height pixels:
// the sum of squared channel differences divided by three times the pixel
// count, unsigned Q16.16 with the fraction truncated, plus a status bit that
// is 1 (and the value 0) when formats, depths or sizes disagree, the format
// is neither raw nor DIB, the depth is not 32, or a size is outside 1..4096.
// Within a frame the block takes one item per cycle. On the closing item of
// a valid frame a bit-serial restoring divider runs, one quotient bit a cycle,
// and no item is taken meanwhile; an invalid frame posts its result at once.
// A result sits in an output register, so the next frame streams in while it
// waits; only the closing item of that frame waits until the previous result
// is taken. Write the registers only while idle.
`default_nettype none

module image_mean_squared_error (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [imse_pkg::ADDR_W-1:0] paddr,
    input  wire logic [imse_pkg::DATA_W-1:0] pwdata,
    output logic      [imse_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    // pixel pair input
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [imse_pkg::CH_W-1:0]   i_orig_c0,
    input  wire logic [imse_pkg::CH_W-1:0]   i_orig_c1,
    input  wire logic [imse_pkg::CH_W-1:0]   i_orig_c2,
    input  wire logic [imse_pkg::CH_W-1:0]   i_cmp_c0,
    input  wire logic [imse_pkg::CH_W-1:0]   i_cmp_c1,
    input  wire logic [imse_pkg::CH_W-1:0]   i_cmp_c2,
    // result output
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_status,
    output logic      [imse_pkg::Q_W-1:0]    o_mse_q16
);

    imse_pkg::t_cfg w_cfg;
    imse_pkg::t_cmd w_cmd;
    imse_pkg::t_sts w_sts;

    // Register file; values are sampled live by the frame checks
    imse_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencing: accumulate, divide, hold the result until taken
    imse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Arithmetic: squared differences, totals, divider, result register
    imse_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_orig_c0 (i_orig_c0),
        .i_orig_c1 (i_orig_c1),
        .i_orig_c2 (i_orig_c2),
        .i_cmp_c0  (i_cmp_c0),
        .i_cmp_c1  (i_cmp_c1),
        .i_cmp_c2  (i_cmp_c2),
        .o_status  (o_status),
        .o_mse_q16 (o_mse_q16)
    );

endmodule

`default_nettype wire
